[rtl/bnf_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bnf_pkg
// Shared constants and types for the binary image neighbor filter.
// ----------------------------------------------------------------------------
package bnf_pkg;

   localparam int MAX_WIDTH  = 256;
   localparam int MAX_HEIGHT = 1024;
   localparam int RAW_DEPTH  = MAX_WIDTH + 1;

   localparam int WIDTH_W  = 9;                     // line_width register
   localparam int HEIGHT_W = 11;                    // frame_height register
   localparam int COL_W    = $clog2(MAX_WIDTH);
   localparam int ROW_W    = $clog2(MAX_HEIGHT);
   localparam int IDX_W    = $clog2(RAW_DEPTH);     // chain cell index
   localparam int COUNT_W  = $clog2(RAW_DEPTH + 1); // held pixel count

   localparam int CSR_ADDR_W = 1;
   localparam int CSR_DATA_W = 11;

   localparam logic [CSR_ADDR_W-1:0] CSR_LINE_WIDTH   = 1'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_FRAME_HEIGHT = 1'd1;

   localparam logic OP_FLUSH = 1'b1;

   localparam logic [WIDTH_W-1:0]  LINE_WIDTH_RESET   = 9'd188;
   localparam logic [HEIGHT_W-1:0] FRAME_HEIGHT_RESET = 11'd120;

   localparam logic [WIDTH_W-1:0]  MIN_DIM    = 9'd3;
   localparam logic [WIDTH_W-1:0]  WIDTH_CAP  = 9'd256;
   localparam logic [HEIGHT_W-1:0] HEIGHT_CAP = 11'd1024;
   localparam logic [2:0]          NEIGH_LIMIT = 3'd2;

   // control broadcast to every cell of the raw pixel chain
   typedef struct packed {
      logic             pop;
      logic             push;
      logic             pixel;
      logic [IDX_W-1:0] push_idx;
      logic             down_en;
      logic [IDX_W-1:0] down_idx;
   } bnf_ctrl_type;

   // taps at the head of the chain
   typedef struct packed {
      logic centre;
      logic right;
      logic down;
   } bnf_head_type;

endpackage

[rtl/bnf_cell.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bnf_cell
// One chain cell: a held raw pixel plus the raw pixel one row below it.
// ----------------------------------------------------------------------------
module bnf_cell
   import bnf_pkg::*;
(
   input  logic             clock,
   input  bnf_ctrl_type     ctrl,
   input  logic [IDX_W-1:0] cell_idx,
   input  logic             nxt_data,
   input  logic             nxt_down,
   output logic             data,
   output logic             down
);

   logic data_ff, data_in;
   logic down_ff, down_in;

   always_comb begin
      data_in = ctrl.pop ? nxt_data : data_ff;
      down_in = ctrl.pop ? nxt_down : down_ff;
      if (ctrl.push && ctrl.push_idx == cell_idx) begin
         data_in = ctrl.pixel;
      end
      if (ctrl.down_en && ctrl.down_idx == cell_idx) begin
         down_in = ctrl.pixel;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
      down_ff <= down_in;
   end

   assign data = data_ff;
   assign down = down_ff;

endmodule

[rtl/bnf_chain.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bnf_chain
// Row of cells holding raw pixels oldest first; a pop shifts toward the head.
// ----------------------------------------------------------------------------
module bnf_chain
   import bnf_pkg::*;
(
   input  logic         clock,
   input  bnf_ctrl_type ctrl,
   output bnf_head_type head
);

   logic data_w [RAW_DEPTH];
   logic down_w [RAW_DEPTH];

   genvar k;
   generate
      for (k = 0; k < RAW_DEPTH; k++) begin : g_cell
         logic nxt_data;
         logic nxt_down;
         if (k == RAW_DEPTH - 1) begin : g_tail
            assign nxt_data = 1'b0;
            assign nxt_down = 1'b0;
         end else begin : g_body
            assign nxt_data = data_w[k+1];
            assign nxt_down = down_w[k+1];
         end
         bnf_cell u_cell (
            .clock    (clock),
            .ctrl     (ctrl),
            .cell_idx (IDX_W'(k)),
            .nxt_data (nxt_data),
            .nxt_down (nxt_down),
            .data     (data_w[k]),
            .down     (down_w[k])
         );
      end
   endgenerate

   assign head.centre = data_w[0];
   assign head.right  = data_w[1];
   assign head.down   = down_w[0];

endmodule

[rtl/binary_image_neighbor_filter.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// binary_image_neighbor_filter
// Four-neighbor denoise filter on a raster-order binary pixel stream.
// ----------------------------------------------------------------------------
// Takes one transaction per clock while req_tready is high and registers its
// result for the next cycle. A filtered pixel leaves line_width+1 pixel
// transactions after it entered; raw pixels wait in a 257-cell chain that
// shifts one place per result, and flush ticks (req_tuser[0]) drain what is
// left at frame end, one pixel each. The row above comes from a 256-entry
// line memory with a registered read. Write csr_* only while no pixels are held.
// ----------------------------------------------------------------------------
module binary_image_neighbor_filter
   import bnf_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [7:0]            req_tdata,   // [0] pixel_in
   input  logic [1:0]            req_tuser,   // [0] op, [1] frame_start
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [7:0]            rsp_tdata,   // [0] pixel_out
   output logic                  rsp_tlast,
   input  logic                  csr_wr_en,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   logic [WIDTH_W-1:0]  lw_ff;
   logic [HEIGHT_W-1:0] fh_ff;
   logic [WIDTH_W-1:0]  w_used;
   logic [HEIGHT_W-1:0] h_used;

   logic [COUNT_W-1:0] count_ff, count_in, count_eff;
   logic [ROW_W-1:0]   out_row_ff, out_row_in, row_eff;
   logic [COL_W-1:0]   out_col_ff, out_col_in, col_eff;
   logic               left_ff, left_in, left_eff;
   logic               up_ff;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_pixel_ff, rsp_last_ff;

   logic               accept, is_flush, fs, emit, push;
   logic               interior, res, last_flag, col_wrap, row_wrap;
   logic [2:0]         sum;
   logic [HEIGHT_W-1:0] row_plus;
   logic [WIDTH_W-1:0]  col_plus;
   logic [IDX_W-1:0]   push_idx;

   bnf_ctrl_type ctrl;
   bnf_head_type head;

   logic row_mem [MAX_WIDTH];

   // configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         lw_ff <= LINE_WIDTH_RESET;
         fh_ff <= FRAME_HEIGHT_RESET;
      end else if (csr_wr_en) begin
         case (csr_addr)
            CSR_LINE_WIDTH:   lw_ff <= csr_wdata[WIDTH_W-1:0];
            CSR_FRAME_HEIGHT: fh_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      w_used = lw_ff;
      if (lw_ff < MIN_DIM) w_used = MIN_DIM;
      if (lw_ff > WIDTH_CAP) w_used = WIDTH_CAP;
      h_used = fh_ff;
      if (fh_ff < HEIGHT_W'(MIN_DIM)) h_used = HEIGHT_W'(MIN_DIM);
      if (fh_ff > HEIGHT_CAP) h_used = HEIGHT_CAP;
   end

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;
   assign is_flush   = (req_tuser[0] == OP_FLUSH);
   assign fs         = accept && !is_flush && req_tuser[1];
   assign push       = accept && !is_flush;

   assign count_eff = fs ? '0 : count_ff;
   assign row_eff   = fs ? '0 : out_row_ff;
   assign col_eff   = fs ? '0 : out_col_ff;
   assign left_eff  = fs ? 1'b0 : left_ff;

   assign emit = accept && (is_flush ? (count_ff != '0) : (count_eff > w_used));

   assign row_plus = {1'b0, row_eff} + HEIGHT_W'(1);
   assign col_plus = {1'b0, col_eff} + WIDTH_W'(1);
   assign col_wrap = col_plus >= w_used;
   assign row_wrap = row_plus >= h_used;

   assign interior = (row_eff != '0) && (row_plus < h_used) && (col_eff != '0) &&
                     (col_plus < w_used) && (count_eff > w_used);
   assign sum = {2'b0, up_ff} + {2'b0, head.down} + {2'b0, head.right} +
                {2'b0, left_eff};

   always_comb begin
      res = head.centre;
      if (interior) begin
         if (!head.centre && sum > NEIGH_LIMIT) res = 1'b1;
         else if (head.centre && sum < NEIGH_LIMIT) res = 1'b0;
      end
   end

   assign last_flag = ({1'b0, row_eff} == h_used - HEIGHT_W'(1)) &&
                      ({1'b0, col_eff} == w_used - WIDTH_W'(1));

   // next positions and count
   always_comb begin
      out_col_in = col_eff;
      out_row_in = row_eff;
      left_in    = left_eff;
      if (emit) begin
         left_in = res;
         if (col_wrap) begin
            out_col_in = '0;
            out_row_in = row_wrap ? '0 : row_plus[ROW_W-1:0];
         end else begin
            out_col_in = col_plus[COL_W-1:0];
         end
      end
      count_in = count_eff - COUNT_W'(emit) + COUNT_W'(push);
   end

   // chain control: new pixel lands after the shift; its row-above partner
   // sits line_width cells closer to the head
   assign push_idx      = count_eff - COUNT_W'(emit);
   assign ctrl.pop      = emit;
   assign ctrl.push     = push;
   assign ctrl.pixel    = req_tdata[0];
   assign ctrl.push_idx = push_idx;
   assign ctrl.down_en  = push && (push_idx >= w_used);
   assign ctrl.down_idx = push_idx - w_used;

   bnf_chain u_chain (
      .clock (clock),
      .ctrl  (ctrl),
      .head  (head)
   );

   // filtered row above, read for the next column
   always_ff @(posedge clock) begin
      if (emit) begin
         row_mem[col_eff] <= res;
      end
      up_ff <= row_mem[out_col_in];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff   <= '0;
         out_row_ff <= '0;
         out_col_ff <= '0;
         left_ff    <= 1'b0;
      end else begin
         count_ff   <= count_in;
         out_row_ff <= out_row_in;
         out_col_ff <= out_col_in;
         left_ff    <= left_in;
      end
   end

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept) rsp_valid_in = emit;
      else if (rsp_tready) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_pixel_ff <= res;
         rsp_last_ff  <= last_flag;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'b0, rsp_pixel_ff};
   assign rsp_tlast  = rsp_last_ff;

   // checks
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_W'(RAW_DEPTH))
      else $error("held pixel count beyond chain depth");

   a_rsp_from_req: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !$past(rsp_tvalid) |-> $past(req_tvalid && req_tready))
      else $error("result without an accepted transaction");

   a_wrap_after_last: assert property (@(posedge clock) disable iff (reset)
      emit && last_flag |=> out_col_ff == '0 && out_row_ff == '0)
      else $error("position not wrapped after last pixel");

   a_flush_drain: assert property (@(posedge clock) disable iff (reset)
      accept && is_flush && count_ff != '0 |=> count_ff == $past(count_ff) - COUNT_W'(1))
      else $error("flush did not drain one pixel");

endmodule
